>>> design/gnss_ubx_rtcm_framer_defines.svh
// Assertion macros for the framer
`ifndef GNSS_UBX_RTCM_FRAMER_DEFINES_SVH
`define GNSS_UBX_RTCM_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define GFRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GFRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GFRM_ASSERT_IMP(lbl, ante, cons, msg)
`define GFRM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/gfrm_pkg.sv
package gfrm_pkg;

	localparam int CNT_W = 32;

	localparam logic [7:0] UBX_SYNC_A    = 8'hB5;
	localparam logic [7:0] UBX_SYNC_B    = 8'h62;
	localparam logic [7:0] RTCM_PREAMBLE = 8'hD3;

	localparam logic [15:0] UBX_RESERVE    = 16'd6;
	localparam logic [15:0] RTCM_RESERVE   = 16'd4;
	localparam logic [15:0] MAX_LEN_LIMIT  = 16'd65529;
	localparam logic [15:0] UBX_BUF_RESET  = 16'd1024;
	localparam logic [15:0] RTCM_BUF_RESET = 16'd1027;

	// class + id + 2 length bytes ahead of the UBX checksum
	localparam logic [16:0] UBX_CK_OFFSET = 17'd4;
	// preamble + 2 length bytes + 3 crc bytes
	localparam logic [16:0] RTCM_OVERHEAD = 17'd6;

	typedef enum logic [7:0] {
		CFG_UBX_BUF  = 8'd0,
		CFG_RTCM_BUF = 8'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		STAT_NONE      = 3'd0,
		STAT_UBX_OK    = 3'd1,
		STAT_UBX_CKERR = 3'd2,
		STAT_RTCM_OK   = 3'd3,
		STAT_TOO_LONG  = 3'd4
	} frame_status_t;

	typedef enum logic [2:0] {
		ST_HUNT      = 3'd0,
		ST_UBX_SYNC2 = 3'd1,
		ST_UBX_HDR   = 3'd2,
		ST_UBX_BODY  = 3'd3,
		ST_RTCM_HDR  = 3'd4,
		ST_RTCM_BODY = 3'd5
	} parse_state_t;

	typedef struct packed {
		logic [15:0] ubx_lim;
		logic [15:0] rtcm_lim;
	} limits_t;

	typedef struct packed {
		logic             in_frame;
		logic             frame_kind;
		logic [7:0]       frame_byte;
		logic [15:0]      byte_index;
		logic             last_of_frame;
		frame_status_t    frame_status;
		logic [CNT_W-1:0] unframed_count;
		logic [CNT_W-1:0] ubx_frame_count;
		logic [CNT_W-1:0] rtcm_frame_count;
		logic [CNT_W-1:0] checksum_error_count;
		logic [CNT_W-1:0] rx_byte_count;
	} result_t;

	function automatic logic [15:0] limit_after(input logic [15:0] buf_bytes,
		input logic [15:0] reserve);
		logic [15:0] d;
		d = (buf_bytes > reserve) ? buf_bytes - reserve : 16'd0;
		return (d > MAX_LEN_LIMIT) ? MAX_LEN_LIMIT : d;
	endfunction

endpackage

>>> design/gfrm_cfg.sv
module gfrm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output gfrm_pkg::limits_t limits
);
	import gfrm_pkg::*;

	logic [15:0] ubx_lim_q;
	logic [15:0] rtcm_lim_q;

	// limits are kept already reduced by the header reserve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ubx_lim_q  <= limit_after(UBX_BUF_RESET, UBX_RESERVE);
			rtcm_lim_q <= limit_after(RTCM_BUF_RESET, RTCM_RESERVE);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_UBX_BUF:  ubx_lim_q  <= limit_after(cfg_data, UBX_RESERVE);
				CFG_RTCM_BUF: rtcm_lim_q <= limit_after(cfg_data, RTCM_RESERVE);
				default: ;
			endcase
		end
	end

	assign limits.ubx_lim  = ubx_lim_q;
	assign limits.rtcm_lim = rtcm_lim_q;

endmodule

>>> design/gfrm_parser.sv
`include "gnss_ubx_rtcm_framer_defines.svh"

module gfrm_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  gfrm_pkg::limits_t limits,
	output gfrm_pkg::result_t res
);
	import gfrm_pkg::*;

	parse_state_t     state_q, state_n;
	logic [15:0]      fcb_q, fcb_n;
	logic [15:0]      pl_q, pl_n;
	logic [7:0]       sum_a_q, sum_a_n;
	logic [7:0]       sum_b_q, sum_b_n;
	logic [7:0]       ck_a_q, ck_a_n;
	logic [CNT_W-1:0] miss_q, miss_n;
	logic [CNT_W-1:0] ubx_ok_q, ubx_ok_n;
	logic [CNT_W-1:0] rtcm_ok_q, rtcm_ok_n;
	logic [CNT_W-1:0] ck_err_q, ck_err_n;
	logic [CNT_W-1:0] bytes_q, bytes_n;
	logic [16:0]      idx_ext;
	logic [16:0]      pl_ext;
	logic [16:0]      fcb_inc_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			fcb_q     <= '0;
			pl_q      <= '0;
			sum_a_q   <= '0;
			sum_b_q   <= '0;
			ck_a_q    <= '0;
			miss_q    <= '0;
			ubx_ok_q  <= '0;
			rtcm_ok_q <= '0;
			ck_err_q  <= '0;
			bytes_q   <= '0;
		end else if (accept) begin
			state_q   <= state_n;
			fcb_q     <= fcb_n;
			pl_q      <= pl_n;
			sum_a_q   <= sum_a_n;
			sum_b_q   <= sum_b_n;
			ck_a_q    <= ck_a_n;
			miss_q    <= miss_n;
			ubx_ok_q  <= ubx_ok_n;
			rtcm_ok_q <= rtcm_ok_n;
			ck_err_q  <= ck_err_n;
			bytes_q   <= bytes_n;
		end
	end

	assign idx_ext     = {1'b0, fcb_q};
	assign pl_ext      = {1'b0, pl_q};
	assign fcb_inc_ext = idx_ext + 17'd1;

	always_comb begin
		state_n   = state_q;
		fcb_n     = fcb_q;
		pl_n      = pl_q;
		sum_a_n   = sum_a_q;
		sum_b_n   = sum_b_q;
		ck_a_n    = ck_a_q;
		miss_n    = miss_q;
		ubx_ok_n  = ubx_ok_q;
		rtcm_ok_n = rtcm_ok_q;
		ck_err_n  = ck_err_q;
		bytes_n   = bytes_q + CNT_W'(1);

		res = '0;
		res.frame_status = STAT_NONE;

		case (state_q)
			ST_UBX_SYNC2: begin
				state_n = (rx_byte == UBX_SYNC_B) ? ST_UBX_HDR : ST_HUNT;
				fcb_n   = '0;
				sum_a_n = '0;
				sum_b_n = '0;
			end
			ST_UBX_HDR: begin
				res.in_frame   = 1'b1;
				res.byte_index = fcb_q;
				sum_a_n = sum_a_q + rx_byte;
				sum_b_n = sum_b_q + sum_a_n;
				fcb_n   = fcb_q + 16'd1;
				if (fcb_q == 16'd2)
					pl_n = {8'h00, rx_byte};
				if (fcb_q == 16'd3) begin
					pl_n = pl_q | {rx_byte, 8'h00};
					if (pl_n > limits.ubx_lim) begin
						res.last_of_frame = 1'b1;
						res.frame_status  = STAT_TOO_LONG;
						state_n = ST_HUNT;
					end else begin
						state_n = ST_UBX_BODY;
					end
				end
			end
			ST_UBX_BODY: begin
				res.in_frame   = 1'b1;
				res.byte_index = fcb_q;
				fcb_n = fcb_q + 16'd1;
				if (idx_ext < pl_ext + UBX_CK_OFFSET) begin
					sum_a_n = sum_a_q + rx_byte;
					sum_b_n = sum_b_q + sum_a_n;
				end else if (idx_ext == pl_ext + UBX_CK_OFFSET) begin
					ck_a_n = rx_byte;
				end else begin
					res.last_of_frame = 1'b1;
					if (ck_a_q == sum_a_q && rx_byte == sum_b_q) begin
						res.frame_status = STAT_UBX_OK;
						ubx_ok_n = ubx_ok_q + CNT_W'(1);
					end else begin
						res.frame_status = STAT_UBX_CKERR;
						ck_err_n = ck_err_q + CNT_W'(1);
					end
					state_n = ST_HUNT;
				end
			end
			ST_RTCM_HDR: begin
				res.in_frame   = 1'b1;
				res.frame_kind = 1'b1;
				res.byte_index = fcb_q;
				fcb_n = fcb_q + 16'd1;
				if (fcb_q == 16'd1) begin
					pl_n = {rx_byte, 8'h00};
				end else begin
					pl_n = pl_q | {8'h00, rx_byte};
					if (pl_n > limits.rtcm_lim) begin
						res.last_of_frame = 1'b1;
						res.frame_status  = STAT_TOO_LONG;
						state_n = ST_HUNT;
					end else begin
						state_n = ST_RTCM_BODY;
					end
				end
			end
			ST_RTCM_BODY: begin
				res.in_frame   = 1'b1;
				res.frame_kind = 1'b1;
				res.byte_index = fcb_q;
				fcb_n = fcb_q + 16'd1;
				if (fcb_inc_ext == pl_ext + RTCM_OVERHEAD) begin
					res.last_of_frame = 1'b1;
					res.frame_status  = STAT_RTCM_OK;
					rtcm_ok_n = rtcm_ok_q + CNT_W'(1);
					state_n = ST_HUNT;
				end
			end
			default: begin
				state_n = ST_HUNT;
				fcb_n   = '0;
				if (rx_byte == UBX_SYNC_A) begin
					state_n = ST_UBX_SYNC2;
				end else if (rx_byte == RTCM_PREAMBLE) begin
					res.in_frame   = 1'b1;
					res.frame_kind = 1'b1;
					fcb_n   = 16'd1;
					pl_n    = '0;
					state_n = ST_RTCM_HDR;
				end else begin
					miss_n = miss_q + CNT_W'(1);
				end
			end
		endcase

		res.frame_byte           = res.in_frame ? rx_byte : 8'h00;
		res.unframed_count       = miss_n;
		res.ubx_frame_count      = ubx_ok_n;
		res.rtcm_frame_count     = rtcm_ok_n;
		res.checksum_error_count = ck_err_n;
		res.rx_byte_count        = bytes_n;
	end

	`GFRM_ASSERT_IMP(a_last_has_status, 1'b1,
		res.last_of_frame == (res.frame_status != STAT_NONE), "last mark and status disagree")
	`GFRM_ASSERT_IMP(a_kind_in_frame, res.frame_kind, res.in_frame, "kind set outside a frame")
	`GFRM_ASSERT_NXT(a_sync2_clears, accept && state_q == ST_UBX_SYNC2,
		fcb_q == 16'd0 && sum_a_q == 8'h00 && sum_b_q == 8'h00, "sync2 did not clear frame")

endmodule

>>> design/gfrm_outbuf.sv
`include "gnss_ubx_rtcm_framer_defines.svh"

module gfrm_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gfrm_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output gfrm_pkg::result_t out_data
);
	import gfrm_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (take) begin
				if (skid_valid_q)
					skid_valid_q <= push;
				else
					main_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q) begin
			if (push)
				main_q <= push_data;
		end else if (take) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push)
					skid_q <= push_data;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	`GFRM_ASSERT_IMP(a_skid_behind_main, skid_valid_q, main_valid_q, "skid word without main word")

endmodule

>>> design/gnss_ubx_rtcm_framer.sv
// UBX / RTCM3 byte framer. One byte is taken per cycle on rx_byte while
// in_stall is low and yields exactly one registered output word. The parser
// state and counters update in the same cycle the byte is taken, so bytes may
// arrive back to back; a two-word output buffer lets the input keep flowing
// for one extra word while the output is stalled, after which in_stall rises.
// UBX checksums are verified, RTCM CRC is not. Limit registers are written
// via the cfg port (always ready), by the user only while idle; not enforced.
module gnss_ubx_rtcm_framer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      in_frame,
	output logic                      frame_kind,
	output logic [7:0]                frame_byte,
	output logic [15:0]               byte_index,
	output logic                      last_of_frame,
	output logic [2:0]                frame_status,
	output logic [gfrm_pkg::CNT_W-1:0] unframed_count,
	output logic [gfrm_pkg::CNT_W-1:0] ubx_frame_count,
	output logic [gfrm_pkg::CNT_W-1:0] rtcm_frame_count,
	output logic [gfrm_pkg::CNT_W-1:0] checksum_error_count,
	output logic [gfrm_pkg::CNT_W-1:0] rx_byte_count
);
	import gfrm_pkg::*;

	limits_t limits;
	result_t res;
	result_t out_word;
	logic    accept;
	logic    buf_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign accept    = in_valid && !buf_full;

	gfrm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	gfrm_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.limits  (limits),
		.res     (res)
	);

	gfrm_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_word)
	);

	assign in_frame             = out_word.in_frame;
	assign frame_kind           = out_word.frame_kind;
	assign frame_byte           = out_word.frame_byte;
	assign byte_index           = out_word.byte_index;
	assign last_of_frame        = out_word.last_of_frame;
	assign frame_status         = out_word.frame_status;
	assign unframed_count       = out_word.unframed_count;
	assign ubx_frame_count      = out_word.ubx_frame_count;
	assign rtcm_frame_count     = out_word.rtcm_frame_count;
	assign checksum_error_count = out_word.checksum_error_count;
	assign rx_byte_count        = out_word.rx_byte_count;

endmodule
